### rtl/core/gre_pkg.sv
// Package for the graph reachability engine: shared constants, opcodes
// and the status struct passed from the controller to the top level.
// No dependencies.
`default_nettype none

package gre_pkg;

  // Vertex fields on the input channel are 4 bits wide
  localparam int VERTEX_W = 4;

  // Default graph size
  localparam int VERTICES_DEFAULT = 16;

  // Opcodes
  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_QUERY    = 1'b1;

  // Controller -> output stage status
  typedef struct packed {
    logic done;       // a query answer is handed over this cycle
    logic reachable;  // the answer
  } gre_result_t;

endpackage

`default_nettype wire

### rtl/core/gre_if.sv
// Channel interfaces for the graph reachability engine: item input and
// result output, each with valid/ready. Depends on gre_pkg.
`default_nettype none

interface gre_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [gre_pkg::VERTEX_W-1:0]  first_vertex;
  logic [gre_pkg::VERTEX_W-1:0]  second_vertex;

  modport source (output valid, output opcode, output first_vertex,
                  output second_vertex, input ready);
  modport sink   (input valid, input opcode, input first_vertex,
                  input second_vertex, output ready);
endinterface

interface gre_out_if;
  logic valid;
  logic ready;
  logic reachable;

  modport source (output valid, output reachable, input ready);
  modport sink   (input valid, input reachable, output ready);
endinterface

`default_nettype wire

### rtl/core/gre_adj_mem.sv
// Adjacency row memory: one row of edge bits per vertex, synchronous read;
// per-row valid flops make reset clear the graph.
// Depends on nothing beyond its parameters.
`default_nettype none

module gre_adj_mem #(
  parameter int VERTICES = 16,
  parameter int AW       = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                rd_en,
  input  wire logic [AW-1:0]       rd_addr,
  output      logic [VERTICES-1:0] rd_data,
  input  wire logic                wr_en,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire logic [VERTICES-1:0] wr_data
);

  logic [VERTICES-1:0] mem [VERTICES];
  logic [VERTICES-1:0] row_valid;
  logic [VERTICES-1:0] rd_q;
  logic                rd_valid_q;

  // Storage array and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Row valid bits: a row never written reads as no edges
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= row_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

`default_nettype wire

### rtl/core/gre_ctrl.sv
// Controller: read-modify-write of adjacency rows for edge inserts, and
// frontier expansion (one row read per cycle while vertices are pending) for reachability queries.
// Depends on gre_pkg, gre_in_if.
`default_nettype none

module gre_ctrl #(
  parameter int VERTICES = 16,
  parameter int AW       = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  gre_in_if.sink                   item,
  output      logic                rd_en,
  output      logic [AW-1:0]       rd_addr,
  input  wire logic [VERTICES-1:0] rd_data,
  output      logic                wr_en,
  output      logic [AW-1:0]       wr_addr,
  output      logic [VERTICES-1:0] wr_data,
  input  wire logic                res_ready,
  output      gre_pkg::gre_result_t res
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_EDGE_WR = 2'd1;
  localparam logic [1:0] S_RUN     = 2'd2;
  localparam logic [1:0] S_DONE    = 2'd3;

  localparam logic [VERTICES-1:0] ONE = {{(VERTICES-1){1'b0}}, 1'b1};

  logic [1:0]          state, state_next;
  logic [VERTICES-1:0] visited, visited_next;
  logic [VERTICES-1:0] pending, pending_next;   // visited, row not yet read
  logic                rd_busy, rd_busy_next;   // row read in flight
  logic [AW-1:0]       src, src_next;
  logic [AW-1:0]       target, target_next;
  logic                answer, answer_next;

  logic                accept;
  logic                first_ok;
  logic                second_ok;
  logic [VERTICES-1:0] visited_m;
  logic [VERTICES-1:0] pending_m;
  logic [VERTICES-1:0] pick_oh;
  logic [AW-1:0]       pick_idx;
  logic                run_finish;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign first_ok   = int'(item.first_vertex) < VERTICES;
  assign second_ok  = int'(item.second_vertex) < VERTICES;

  // Merge the returned row into the visited and pending sets
  assign visited_m = rd_busy ? (visited | rd_data) : visited;
  assign pending_m = rd_busy ? (pending | (rd_data & ~visited)) : pending;

  // Lowest pending vertex is expanded next
  assign pick_oh = pending & (~pending + ONE);

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < VERTICES; i++) begin
      if (pick_oh[i]) begin
        pick_idx = pick_idx | AW'(i);
      end
    end
  end

  // Stop once the target is seen or nothing is left to expand
  assign run_finish = visited_m[target] || ((pending == '0) && !rd_busy);

  // Next-state logic
  always_comb begin
    state_next   = state;
    visited_next = visited;
    pending_next = pending;
    rd_busy_next = 1'b0;
    src_next     = src;
    target_next  = target;
    answer_next  = answer;
    rd_en        = 1'b0;
    rd_addr      = AW'(item.first_vertex);
    wr_en        = 1'b0;
    wr_addr      = src;
    wr_data      = rd_data | (ONE << target);
    res.done      = 1'b0;
    res.reachable = answer;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          src_next    = AW'(item.first_vertex);
          target_next = AW'(item.second_vertex);
          if (item.opcode == gre_pkg::OP_ADD_EDGE) begin
            if (first_ok && second_ok) begin
              rd_en      = 1'b1;
              state_next = S_EDGE_WR;
            end
          end else if (first_ok && second_ok) begin
            visited_next = ONE << AW'(item.first_vertex);
            pending_next = ONE << AW'(item.first_vertex);
            state_next   = S_RUN;
          end else begin
            answer_next = 1'b0;
            state_next  = S_DONE;
          end
        end
      end
      S_EDGE_WR: begin
        wr_en      = 1'b1;
        state_next = S_IDLE;
      end
      S_RUN: begin
        visited_next = visited_m;
        if (run_finish) begin
          answer_next  = visited_m[target];
          pending_next = '0;
          state_next   = S_DONE;
        end else begin
          pending_next = pending_m;
          if (pending != '0) begin
            rd_en        = 1'b1;
            rd_addr      = pick_idx;
            rd_busy_next = 1'b1;
            pending_next = pending_m & ~pick_oh;
          end
        end
      end
      S_DONE: begin
        res.done = res_ready;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_busy <= 1'b0;
      visited <= '0;
      pending <= '0;
    end else begin
      state   <= state_next;
      rd_busy <= rd_busy_next;
      visited <= visited_next;
      pending <= pending_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    src    <= src_next;
    target <= target_next;
    answer <= answer_next;
  end

  // Pending vertices are always part of the visited set
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> ((pending & ~visited) == '0))
    else $error("pending vertex outside visited set");

  // Visited set only grows while a query runs
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && $past(state) == S_RUN) |->
      (($past(visited) & ~visited) == '0))
    else $error("visited set lost a vertex during a query");

  // The memory port never reads and writes in the same cycle
  assert property (@(posedge clk) disable iff (rst) !(rd_en && wr_en))
    else $error("row read and write collide");

endmodule

`default_nettype wire

### rtl/core/graph_reachability_engine.sv
// Add edge: row read, then row write back; no result transaction.
// Query: seed step, then one row read per cycle while vertices are pending, a bubble
// while the next vertex waits on the row in flight; the answer passes the controller's
// done state, then the output register. Out-of-range query: answered 0. One item at a time.
// rst (synchronous) clears all row valid bits together: no clearing pass.
// Depends on gre_pkg, gre_if, gre_adj_mem, gre_ctrl.
`default_nettype none

module graph_reachability_engine #(
  parameter int VERTICES = gre_pkg::VERTICES_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  gre_in_if.sink    item,
  gre_out_if.source result
);

  localparam int AW = (VERTICES > 1) ? $clog2(VERTICES) : 1;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [VERTICES-1:0]  rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [VERTICES-1:0]  wr_data;
  logic                 res_ready;
  gre_pkg::gre_result_t res;
  logic                 out_valid;
  logic                 out_reachable;

  gre_adj_mem #(
    .VERTICES (VERTICES),
    .AW       (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  gre_ctrl #(
    .VERTICES (VERTICES),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: free when empty or being taken this cycle
  assign res_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.done) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      out_reachable <= res.reachable;
    end
  end

  assign result.valid     = out_valid;
  assign result.reachable = out_reachable;

endmodule

`default_nettype wire

### bench/tb.sv
// Testbench for graph_reachability_engine: edge-add and reachability query
// transactions, with answers checked against a scoreboard that tracks the graph.
// Depends on gre_pkg, gre_if and the engine RTL.

module tb;

  localparam int NV               = gre_pkg::VERTICES_DEFAULT;
  localparam int VW               = gre_pkg::VERTEX_W;
  localparam int IDLE_PCT         = 13;
  localparam int HOLD_CYCLES      = 400;
  localparam int DRAIN_CYCLES     = 4 * NV + 8;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int FORWARD_ITEMS    = 800;   // edges only go to an equal or higher vertex
  localparam int ANY_ITEMS        = 700;   // edges in any direction

  // Tracks the graph, predicts each query answer and checks the answers in order
  class reach_scoreboard;
    logic [NV-1:0] adj_rows [NV];
    logic          answers_due [$];
    int unsigned   errors, edges_added, queries, answers_seen, hits;

    function new();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      errors = 0;
      edges_added = 0;
      queries = 0;
      answers_seen = 0;
      hits = 0;
    endfunction

    // Vertices reachable from start, one frontier step at a time
    function logic [NV-1:0] reach_set(int unsigned start);
      logic [NV-1:0] seen, wave, nxt;
      seen = '0;
      seen[start] = 1'b1;
      wave = seen;
      for (int step = 0; step < NV && wave != '0; step++) begin
        nxt = '0;
        for (int v = 0; v < NV; v++)
          if (wave[v]) nxt |= adj_rows[v];
        wave = nxt & ~seen;
        seen |= wave;
      end
      return seen;
    endfunction

    function void note_item(logic op, logic [VW-1:0] a, logic [VW-1:0] b);
      logic [NV-1:0] seen;
      if (op == gre_pkg::OP_ADD_EDGE) begin
        edges_added++;
        if (a < NV && b < NV) adj_rows[a][b] = 1'b1;
      end else begin
        queries++;
        // a vertex that does not exist reaches nothing
        if (a >= NV || b >= NV) begin
          answers_due.push_back(1'b0);
        end else begin
          seen = reach_set(a);
          answers_due.push_back(seen[b]);
        end
      end
    endfunction

    function void check_result(logic got);
      logic want;
      answers_seen++;
      if (got === 1'b1) hits++;
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected answer transaction, expected none, actual %b", $time, got);
      end else begin
        want = answers_due.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: reachable mismatch, expected %b, actual %b", $time, want, got);
        end
      end
    endfunction

    function int unsigned pending();
      return answers_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  int unsigned cycles = 0;
  bit          src_steady = 1'b0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  reach_scoreboard sb;

  gre_in_if  item_ch ();
  gre_out_if result_ch ();

  graph_reachability_engine #(.VERTICES(NV)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d answers still due", cycles, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one item and wait until the engine takes it
  task automatic send_item(input logic op, input logic [VW-1:0] src,
                           input logic [VW-1:0] dst);
    while (!src_steady && $urandom_range(99) < IDLE_PCT) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.opcode        <= op;
    item_ch.first_vertex  <= src;
    item_ch.second_vertex <= dst;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_item(op, src, dst);
  endtask

  // Result side: check every transaction, stall at random, one long hold-off, one always-ready stretch
  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (result_ch.valid && result_ch.ready) sb.check_result(result_ch.reachable);
      if (!hold_done && sb.answers_seen >= 100) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (sb.answers_seen >= 600 && sb.answers_seen < 900) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
      @(posedge clk);
    end
  end

  // Stimulus
  initial begin
    logic          op;
    logic [VW-1:0] a, b;

    sb = new();
    item_ch.valid         <= 1'b0;
    item_ch.opcode        <= gre_pkg::OP_ADD_EDGE;
    item_ch.first_vertex  <= '0;
    item_ch.second_vertex <= '0;
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty graph, chain, repeated edge, self edges, cycle, dead end
    send_item(gre_pkg::OP_QUERY,    4'd0,  4'd0);
    send_item(gre_pkg::OP_QUERY,    4'd0,  4'd15);
    send_item(gre_pkg::OP_QUERY,    4'd15, 4'd15);
    send_item(gre_pkg::OP_ADD_EDGE, 4'd0,  4'd1);
    send_item(gre_pkg::OP_ADD_EDGE, 4'd1,  4'd2);
    send_item(gre_pkg::OP_ADD_EDGE, 4'd2,  4'd15);
    send_item(gre_pkg::OP_QUERY,    4'd0,  4'd15);
    send_item(gre_pkg::OP_QUERY,    4'd15, 4'd0);
    send_item(gre_pkg::OP_ADD_EDGE, 4'd2,  4'd15);
    send_item(gre_pkg::OP_QUERY,    4'd1,  4'd15);
    send_item(gre_pkg::OP_ADD_EDGE, 4'd7,  4'd7);
    send_item(gre_pkg::OP_QUERY,    4'd7,  4'd0);
    send_item(gre_pkg::OP_QUERY,    4'd7,  4'd7);
    send_item(gre_pkg::OP_QUERY,    4'd8,  4'd3);
    send_item(gre_pkg::OP_ADD_EDGE, 4'd15, 4'd0);
    send_item(gre_pkg::OP_QUERY,    4'd15, 4'd2);
    send_item(gre_pkg::OP_QUERY,    4'd1,  4'd0);
    send_item(gre_pkg::OP_ADD_EDGE, 4'd15, 4'd15);
    send_item(gre_pkg::OP_QUERY,    4'd2,  4'd1);
    send_item(gre_pkg::OP_QUERY,    4'd3,  4'd3);

    // Random, forward edges only: answers stay mixed for a long time
    for (int i = 0; i < FORWARD_ITEMS; i++) begin
      src_steady = (i >= 500 && i < 800);
      op = ($urandom_range(99) < 10) ? gre_pkg::OP_ADD_EDGE : gre_pkg::OP_QUERY;
      a  = VW'($urandom_range(NV - 1));
      b  = (op == gre_pkg::OP_ADD_EDGE) ? VW'($urandom_range(NV - 1, a))
                                        : VW'($urandom_range(NV - 1));
      send_item(op, a, b);
    end
    src_steady = 1'b0;

    // Random, edges in any direction: back edges close cycles
    for (int i = 0; i < ANY_ITEMS; i++) begin
      op = ($urandom_range(99) < 6) ? gre_pkg::OP_ADD_EDGE : gre_pkg::OP_QUERY;
      a  = VW'($urandom_range(NV - 1));
      b  = VW'($urandom_range(NV - 1));
      send_item(op, a, b);
    end
    item_ch.valid <= 1'b0;

    // Drain, then give a trailing edge add time to settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run sent %0d edge adds and %0d queries; %0d answers checked, %0d reachable.",
             sb.edges_added, sb.queries, sb.answers_seen, sb.hits);
    $display("Included a %0d-cycle result hold-off; %0d mismatches in %0d cycles.",
             HOLD_CYCLES, sb.errors, cycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
